// File: hdl/fat_file_sector_sequencer_assert.svh
// Assertion macros shared by the FAT sector sequencer RTL.
`ifndef FAT_FILE_SECTOR_SEQUENCER_ASSERT_SVH
`define FAT_FILE_SECTOR_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

`define FFSS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffss assertion failed");

`define FFSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffss assertion failed");

`else

`define FFSS_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define FFSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/ffss_pkg.sv
// Types and constants of the FAT sector sequencer.
`timescale 1ns / 1ps

package ffss_pkg;

   localparam int unsigned SECTOR_W    = 32;
   localparam int unsigned CLUSTER_W   = 28;
   localparam int unsigned ENTRY_W     = 32;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned SPC_W       = 8;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 48;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned ACTION_W    = 3;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_OPEN  = 2'd0;
   localparam kind_type KIND_NEXT  = 2'd1;
   localparam kind_type KIND_REPLY = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_OPENED = 3'd0,
      ACT_READ   = 3'd1,
      ACT_FETCH  = 3'd2,
      ACT_EOF    = 3'd3,
      ACT_ERROR  = 3'd4
   } action_type;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_FAT32_MODE  = 2'd0;
   localparam csr_addr_type CSR_SPC         = 2'd1;
   localparam csr_addr_type CSR_FIRST_FAT   = 2'd2;
   localparam csr_addr_type CSR_FIRST_DATA  = 2'd3;

   localparam logic [CLUSTER_W-1:0] FAT32_END = 28'hFFFFFF8;
   localparam logic [CLUSTER_W-1:0] FAT32_BAD = 28'hFFFFFF7;
   localparam logic [15:0]          FAT16_END = 16'hFFF8;
   localparam logic [15:0]          FAT16_BAD = 16'hFFF7;

   localparam int unsigned FAT32_SHIFT = 7;
   localparam int unsigned FAT16_SHIFT = 8;

endpackage

// File: hdl/fat_file_sector_sequencer.sv
// Top level of the FAT sector sequencer: walks a cluster chain into sector addresses.
// A request beat is held in the request register, and its result beat then in the result register.
// Throughput: one request beat per cycle, limited only by rsp_tready backpressure.
// The request register and the result register let a new beat in while a result waits.
// A synchronous active-high reset clears the chain state (all but the offset register), the cache and all valid flags.
// After reset the configuration holds FAT16 mode, one sector per cluster, and zero bases.
`timescale 1ns / 1ps
`include "fat_file_sector_sequencer_assert.svh"

module fat_file_sector_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_cluster[27:0], fat_entry[59:28], reply_ok[60], zero[63:61]
   input  logic [ffss_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // kind[1:0]
   input  logic [ffss_pkg::KIND_W-1:0]           req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // sector_address[31:0], entry_index[39:32], load_needed[40], zero[47:41]
   output logic [ffss_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // action[2:0]
   output logic [ffss_pkg::ACTION_W-1:0]         rsp_tuser,
   input  logic                                  csr_we,
   input  logic [ffss_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ffss_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int unsigned SW = ffss_pkg::SECTOR_W;
   localparam int unsigned CW = ffss_pkg::CLUSTER_W;
   localparam int unsigned PW = ffss_pkg::SECTOR_W + ffss_pkg::SPC_W;

   // Configuration registers.
   logic                          fat32_ff, fat32_in;
   logic [ffss_pkg::SPC_W-1:0]    spc_ff, spc_in;
   logic [SW-1:0]                 ffs_ff, ffs_in;
   logic [SW-1:0]                 fds_ff, fds_in;

   // Chain state.
   logic [CW-1:0]                 cur_ff, cur_in;
   logic [SW-1:0]                 cs_ff, cs_in;
   logic [SW-1:0]                 cached_ff, cached_in;
   logic                          cache_valid_ff, cache_valid_in;
   logic [SW-1:0]                 pending_ff, pending_in;
   logic                          awaiting_ff, awaiting_in;
   logic [SW-1:0]                 off_ff, off_in;

   // Request register stage.
   logic                          s1_valid_ff, s1_valid_in;
   ffss_pkg::kind_type            s1_kind_ff;
   logic [CW-1:0]                 s1_start_ff;
   logic [CW-1:0]                 s1_val_ff;
   logic                          s1_ok_ff;
   logic                          s1_end_ff;
   logic                          s1_bad_ff;
   logic [SW-1:0]                 s1_prod_ff;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   ffss_pkg::action_type          rsp_act_ff, rsp_act_in;
   logic [SW-1:0]                 rsp_addr_ff, rsp_addr_in;
   logic [ffss_pkg::INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                          rsp_ld_ff, rsp_ld_in;

   // Request decode.
   ffss_pkg::kind_type            req_kind;
   logic [CW-1:0]                 req_start;
   logic [ffss_pkg::ENTRY_W-1:0]  req_raw;
   logic                          req_ok;
   logic [CW-1:0]                 dec_val;
   logic                          dec_end;
   logic                          dec_bad;
   logic [CW-1:0]                 dec_cluster;
   logic [PW-1:0]                 dec_prod;
   logic                          req_fire;

   // Processing.
   logic                          out_free;
   logic                          s1_has_rsp;
   logic                          s1_adv;
   logic                          s2_fire;
   logic [SW-1:0]                 data_base;
   logic                          at_cluster_end;
   logic [ffss_pkg::INDEX_W-1:0]  fetch_idx;
   logic [SW-1:0]                 pend_cand;
   logic                          ld_pending;
   logic                          ld_cand;
   logic [PW-1:0]                 off_prod;

   assign req_kind  = req_tuser;
   assign req_start = req_tdata[CW-1:0];
   assign req_raw   = req_tdata[CW+ffss_pkg::ENTRY_W-1:CW];
   assign req_ok    = req_tdata[CW+ffss_pkg::ENTRY_W];

   always_comb begin
      if (fat32_ff) begin
         dec_val = req_raw[CW-1:0];
         dec_end = (req_raw[CW-1:0] >= ffss_pkg::FAT32_END);
         dec_bad = (req_raw[CW-1:0] < CW'(2)) || (req_raw[CW-1:0] == ffss_pkg::FAT32_BAD);
      end else begin
         dec_val = CW'(req_raw[15:0]);
         dec_end = (req_raw[15:0] >= ffss_pkg::FAT16_END);
         dec_bad = (req_raw[15:0] < 16'd2) || (req_raw[15:0] == ffss_pkg::FAT16_BAD);
      end
      dec_cluster = (req_kind == ffss_pkg::KIND_OPEN) ? req_start : dec_val;
      dec_prod = PW'(SW'({{(SW-CW){1'b0}}, dec_cluster}) - SW'(2)) * PW'(spc_ff);
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_has_rsp = (s1_kind_ff == ffss_pkg::KIND_OPEN) ||
                       (s1_kind_ff == ffss_pkg::KIND_NEXT) ||
                       (s1_kind_ff == ffss_pkg::KIND_REPLY);
   assign s2_fire    = s1_valid_ff && s1_has_rsp && out_free;
   assign s1_adv     = s1_valid_ff && (out_free || !s1_has_rsp);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
   end

   // Configuration writes.
   always_comb begin
      fat32_in = fat32_ff;
      spc_in   = spc_ff;
      ffs_in   = ffs_ff;
      fds_in   = fds_ff;
      if (csr_we) begin
         case (csr_addr)
            ffss_pkg::CSR_FAT32_MODE: fat32_in = csr_wdata[0];
            ffss_pkg::CSR_SPC:        spc_in   = csr_wdata[ffss_pkg::SPC_W-1:0];
            ffss_pkg::CSR_FIRST_FAT:  ffs_in   = csr_wdata[SW-1:0];
            ffss_pkg::CSR_FIRST_DATA: fds_in   = csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Shared terms of the processing stage.
   assign data_base      = fds_ff + s1_prod_ff;
   assign at_cluster_end = (cs_ff == fds_ff + off_ff);
   assign fetch_idx      = fat32_ff ? {1'b0, cur_ff[ffss_pkg::FAT32_SHIFT-1:0]}
                                    : cur_ff[ffss_pkg::FAT16_SHIFT-1:0];
   assign pend_cand      = ffs_ff + (fat32_ff ? SW'(cur_ff >> ffss_pkg::FAT32_SHIFT)
                                              : SW'(cur_ff >> ffss_pkg::FAT16_SHIFT));
   assign ld_pending     = !(cache_valid_ff && (cached_ff == pending_ff));
   assign ld_cand        = !(cache_valid_ff && (cached_ff == pend_cand));

   always_comb begin
      cur_in         = cur_ff;
      cs_in          = cs_ff;
      cached_in      = cached_ff;
      cache_valid_in = cache_valid_ff;
      pending_in     = pending_ff;
      awaiting_in    = awaiting_ff;
      rsp_act_in     = ffss_pkg::ACT_ERROR;
      rsp_addr_in    = '0;
      rsp_idx_in     = '0;
      rsp_ld_in      = 1'b0;
      case (s1_kind_ff)
         ffss_pkg::KIND_OPEN: begin
            rsp_act_in  = ffss_pkg::ACT_OPENED;
            rsp_addr_in = data_base;
            if (s2_fire) begin
               awaiting_in = 1'b0;
               cur_in      = s1_start_ff;
               cs_in       = data_base;
            end
         end
         ffss_pkg::KIND_NEXT: begin
            if (awaiting_ff) begin
               rsp_act_in  = ffss_pkg::ACT_FETCH;
               rsp_addr_in = pending_ff;
               rsp_idx_in  = fetch_idx;
               rsp_ld_in   = ld_pending;
            end else if (at_cluster_end) begin
               rsp_act_in  = ffss_pkg::ACT_FETCH;
               rsp_addr_in = pend_cand;
               rsp_idx_in  = fetch_idx;
               rsp_ld_in   = ld_cand;
               if (s2_fire) begin
                  pending_in  = pend_cand;
                  awaiting_in = 1'b1;
               end
            end else begin
               rsp_act_in  = ffss_pkg::ACT_READ;
               rsp_addr_in = cs_ff;
               if (s2_fire) begin
                  cs_in = cs_ff + SW'(1);
               end
            end
         end
         ffss_pkg::KIND_REPLY: begin
            if (!awaiting_ff || !s1_ok_ff) begin
               rsp_act_in = ffss_pkg::ACT_ERROR;
               if (s2_fire) begin
                  awaiting_in = 1'b0;
               end
            end else begin
               if (s1_end_ff) begin
                  rsp_act_in = ffss_pkg::ACT_EOF;
               end else if (s1_bad_ff) begin
                  rsp_act_in = ffss_pkg::ACT_ERROR;
               end else begin
                  rsp_act_in  = ffss_pkg::ACT_READ;
                  rsp_addr_in = data_base;
               end
               if (s2_fire) begin
                  awaiting_in    = 1'b0;
                  cached_in      = pending_ff;
                  cache_valid_in = 1'b1;
                  if (!s1_end_ff && !s1_bad_ff) begin
                     cur_in = s1_val_ff;
                     cs_in  = data_base + SW'(1);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Offset of the following cluster's first sector, kept in step with the
   // current cluster and the cluster size.
   assign off_prod = PW'(SW'({{(SW-CW){1'b0}}, CW'(cur_in + CW'(1))}) - SW'(2)) * PW'(spc_in);
   assign off_in   = off_prod[SW-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fat32_ff       <= 1'b0;
         spc_ff         <= ffss_pkg::SPC_W'(1);
         ffs_ff         <= '0;
         fds_ff         <= '0;
         cur_ff         <= '0;
         cs_ff          <= '0;
         cached_ff      <= '0;
         cache_valid_ff <= 1'b0;
         pending_ff     <= '0;
         awaiting_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fat32_ff       <= fat32_in;
         spc_ff         <= spc_in;
         ffs_ff         <= ffs_in;
         fds_ff         <= fds_in;
         cur_ff         <= cur_in;
         cs_ff          <= cs_in;
         cached_ff      <= cached_in;
         cache_valid_ff <= cache_valid_in;
         pending_ff     <= pending_in;
         awaiting_ff    <= awaiting_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      if (req_fire) begin
         s1_kind_ff  <= req_kind;
         s1_start_ff <= req_start;
         s1_val_ff   <= dec_val;
         s1_ok_ff    <= req_ok;
         s1_end_ff   <= dec_end;
         s1_bad_ff   <= dec_bad;
         s1_prod_ff  <= dec_prod[SW-1:0];
      end
      if (s2_fire) begin
         rsp_act_ff  <= rsp_act_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_idx_ff  <= rsp_idx_in;
         rsp_ld_ff   <= rsp_ld_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tdata  = {{(ffss_pkg::RSP_TDATA_W - SW - ffss_pkg::INDEX_W - 1){1'b0}},
                        rsp_ld_ff, rsp_idx_ff, rsp_addr_ff};

   `FFSS_ASSERT_NEXT(a_fetch_sets_wait, clock, reset, s2_fire && (rsp_act_in == ffss_pkg::ACT_FETCH), awaiting_ff)
   `FFSS_ASSERT_NEXT(a_cache_stays_valid, clock, reset, cache_valid_ff, cache_valid_ff)
   `FFSS_ASSERT_SAME(a_only_fetch_loads, clock, reset, rsp_valid_ff && (rsp_act_ff != ffss_pkg::ACT_FETCH), !rsp_ld_ff && (rsp_idx_ff == '0))
   `FFSS_ASSERT_SAME(a_end_has_no_addr, clock, reset, rsp_valid_ff && ((rsp_act_ff == ffss_pkg::ACT_EOF) || (rsp_act_ff == ffss_pkg::ACT_ERROR)), rsp_addr_ff == '0)
   `FFSS_ASSERT_SAME(a_stall_means_full, clock, reset, !req_tready, s1_valid_ff && rsp_valid_ff && !rsp_tready)

endmodule
